### rtl/core/utf8d_pkg.sv
`default_nettype none

package utf8d_pkg;

   localparam logic [20:0] REPLACEMENT  = 21'd63;
   localparam logic [20:0] MIN_TWO      = 21'h000080;
   localparam logic [20:0] MIN_THREE    = 21'h000800;
   localparam logic [20:0] MIN_FOUR     = 21'h010000;
   localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW     = 21'h00D800;
   localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;

   localparam logic [7:0]  LEAD_TWO_LO   = 8'hC2;
   localparam logic [7:0]  LEAD_THREE_LO = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR_LO  = 8'hF0;
   localparam logic [7:0]  LEAD_FOUR_HI  = 8'hF4;

   localparam logic [1:0]  CNT_NONE  = 2'd0;
   localparam logic [1:0]  CNT_ONE   = 2'd1;
   localparam logic [1:0]  CNT_TWO   = 2'd2;
   localparam logic [1:0]  CNT_THREE = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Results that one decoded byte pushes into the response queue.
   typedef struct packed {
      logic [1:0]  count;
      logic [20:0] code0;
      logic [20:0] code1;
      logic        text_end;
   } utf8d_result_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        last_of_run;
      logic        end_of_text;
   } utf8d_entry_type;

   // Number of continuation bytes announced by a lead byte; zero when the
   // byte cannot open a multi-byte sequence.
   function automatic logic [1:0] lead_count(input logic [7:0] b);
      logic [1:0] cnt;
      cnt = CNT_NONE;
      if (b >= LEAD_FOUR_LO && b <= LEAD_FOUR_HI) begin
         cnt = CNT_THREE;
      end else if (b >= LEAD_THREE_LO && b < LEAD_FOUR_LO) begin
         cnt = CNT_TWO;
      end else if (b >= LEAD_TWO_LO && b < LEAD_THREE_LO) begin
         cnt = CNT_ONE;
      end
      return cnt;
   endfunction

   // Overlong forms, surrogates and values beyond the code space are replaced.
   function automatic logic [20:0] finish_value(input logic [20:0] code,
                                                input logic [1:0]  len);
      logic [20:0] minimum;
      logic [20:0] value;
      minimum = (len == CNT_ONE) ? MIN_TWO : (len == CNT_TWO) ? MIN_THREE : MIN_FOUR;
      value = code;
      if (code < minimum || code > MAX_SCALAR) begin
         value = REPLACEMENT;
      end else if (code >= SURR_LOW && code <= SURR_HIGH) begin
         value = REPLACEMENT;
      end
      return value;
   endfunction

endpackage

`default_nettype wire

### rtl/core/utf8d_if.sv
`default_nettype none

interface utf8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] bytes_following;

   modport source (output valid, output data_byte, output bytes_following, input ready);
   modport sink (input valid, input data_byte, input bytes_following, output ready);
endinterface

interface utf8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        last_of_run;
   logic        end_of_text;

   modport source (output valid, output code_point, output last_of_run,
                   output end_of_text, input ready);
   modport sink (input valid, input code_point, input last_of_run,
                 input end_of_text, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8d_decode.sv
`default_nettype none

module utf8d_decode (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [7:0]                  data_byte,
   input  wire logic [1:0]                  bytes_following,
   output utf8d_pkg::utf8d_result_type      result
);

   logic [1:0]  pending_ff, pending_in;
   logic [1:0]  length_ff, length_in;
   logic [20:0] partial_ff, partial_in;

   always_comb begin
      logic [1:0]  cnt;
      logic        lead_emits;
      logic [20:0] lead_code;
      logic [20:0] lead_partial;
      logic [20:0] shifted;
      logic [1:0]  pend_dec;
      logic        is_cont;

      cnt        = utf8d_pkg::lead_count(data_byte);
      lead_emits = !data_byte[7] || cnt == utf8d_pkg::CNT_NONE || cnt > bytes_following;
      lead_code  = data_byte[7] ? utf8d_pkg::REPLACEMENT : {13'd0, data_byte};
      unique case (cnt)
         utf8d_pkg::CNT_ONE:   lead_partial = {16'd0, data_byte[4:0]};
         utf8d_pkg::CNT_TWO:   lead_partial = {17'd0, data_byte[3:0]};
         utf8d_pkg::CNT_THREE: lead_partial = {18'd0, data_byte[2:0]};
         default:              lead_partial = '0;
      endcase
      shifted  = {partial_ff[14:0], data_byte[5:0]};
      pend_dec = pending_ff - 2'd1;
      is_cont  = data_byte[7:6] == 2'b10;

      pending_in      = pending_ff;
      length_in       = length_ff;
      partial_in      = partial_ff;
      result.count    = 2'd0;
      result.code0    = utf8d_pkg::REPLACEMENT;
      result.code1    = lead_code;
      result.text_end = bytes_following == 2'd0;

      if (pending_ff != 2'd0) begin
         if (is_cont) begin
            if (pend_dec == 2'd0) begin
               result.count = 2'd1;
               result.code0 = utf8d_pkg::finish_value(shifted, length_ff);
               pending_in   = '0;
               length_in    = '0;
               partial_in   = '0;
            end else if (bytes_following == 2'd0) begin
               // Text ended in the middle of a sequence.
               result.count = 2'd1;
               pending_in   = '0;
               length_in    = '0;
               partial_in   = '0;
            end else begin
               pending_in = pend_dec;
               partial_in = shifted;
            end
         end else begin
            // The broken sequence gives a replacement, then the byte is
            // taken again as a lead.
            if (lead_emits) begin
               result.count = 2'd2;
               pending_in   = '0;
               length_in    = '0;
               partial_in   = '0;
            end else begin
               result.count = 2'd1;
               pending_in   = cnt;
               length_in    = cnt;
               partial_in   = lead_partial;
            end
         end
      end else begin
         if (lead_emits) begin
            result.count = 2'd1;
            result.code0 = lead_code;
         end else begin
            pending_in = cnt;
            length_in  = cnt;
            partial_in = lead_partial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         length_ff  <= '0;
         partial_ff <= '0;
      end else if (advance) begin
         pending_ff <= pending_in;
         length_ff  <= length_in;
         partial_ff <= partial_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/utf8d_rsp_queue.sv
`default_nettype none

module utf8d_rsp_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire utf8d_pkg::utf8d_result_type result,
   output logic                             room,
   utf8d_rsp_if.source                      rsp_chan
);

   utf8d_pkg::utf8d_entry_type entry_ff [utf8d_pkg::QUEUE_DEPTH];

   logic [utf8d_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utf8d_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utf8d_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [utf8d_pkg::QUEUE_CNT_W-1:0] push_n;
   logic                              pop;
   utf8d_pkg::utf8d_entry_type        first_entry;
   utf8d_pkg::utf8d_entry_type        second_entry;

   // A byte may push two responses, so a new one is taken only with two free slots.
   assign room = count_ff <= utf8d_pkg::QUEUE_CNT_W'(utf8d_pkg::QUEUE_DEPTH - 2);

   assign push_n = push ? {1'b0, result.count} : '0;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   assign first_entry.code_point   = result.code0;
   assign first_entry.last_of_run  = result.count == 2'd1;
   assign first_entry.end_of_text  = result.count == 2'd1 && result.text_end;
   assign second_entry.code_point  = result.code1;
   assign second_entry.last_of_run = 1'b1;
   assign second_entry.end_of_text = result.text_end;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[utf8d_pkg::QUEUE_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + utf8d_pkg::QUEUE_PTR_W'(pop);
      count_in  = count_ff + push_n - utf8d_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         entry_ff[wr_ptr_ff] <= first_entry;
      end
      if (push_n == utf8d_pkg::QUEUE_CNT_W'(2)) begin
         entry_ff[wr_ptr_ff + 1'b1] <= second_entry;
      end
   end

   assign rsp_chan.valid       = count_ff != '0;
   assign rsp_chan.code_point  = entry_ff[rd_ptr_ff].code_point;
   assign rsp_chan.last_of_run = entry_ff[rd_ptr_ff].last_of_run;
   assign rsp_chan.end_of_text = entry_ff[rd_ptr_ff].end_of_text;

endmodule

`default_nettype wire

### rtl/core/utf8_validating_decoder.sv
// Path: an accepted request is held in the input register, then written into the
// response queue, which offers it; a queue without room holds it in the register.
// Throughput: one request per cycle while the queue has room; the response queue
// drains one response per cycle while ready, so two-response bytes can fill it.
// Reset: synchronous, active high; clears the open sequence, the input
// register and the response queue.
`default_nettype none

module utf8_validating_decoder (
   input  wire logic   clock,
   input  wire logic   reset,
   utf8d_req_if.sink   req_chan,
   utf8d_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [1:0] in_follow_ff;
   logic       advance;
   logic       room;
   logic       accept;

   utf8d_pkg::utf8d_result_type result;

   assign advance        = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff   <= req_chan.data_byte;
         in_follow_ff <= req_chan.bytes_following;
      end
   end

   utf8d_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .data_byte       (in_byte_ff),
      .bytes_following (in_follow_ff),
      .result          (result)
   );

   utf8d_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (advance),
      .result   (result),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/core/utf8d_checker.sv
`default_nettype none

module utf8d_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [20:0] code_point,
   input wire logic        last_of_run,
   input wire logic        end_of_text
);

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_point))
      else $error("stalled response changed");

   // Nothing is left over from before reset, and a request is taken at once.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

   // Only the final response of a byte can close the text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && end_of_text |-> last_of_run)
      else $error("end of text on a response that is not last");

   // Every response is a Unicode scalar value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> code_point <= 21'h10FFFF
                    && !(code_point >= 21'h00D800 && code_point <= 21'h00DFFF))
      else $error("response is not a scalar value");

endmodule

bind utf8_validating_decoder utf8d_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .code_point  (rsp_chan.code_point),
   .last_of_run (rsp_chan.last_of_run),
   .end_of_text (rsp_chan.end_of_text)
);

`default_nettype wire

### verif/testbench.sv
module testbench;

   localparam int BYTE_TARGET = 650;
   localparam int CYCLE_LIMIT = 400000;

   // Tracks the decoder state for every accepted request and queues the code
   // points that the block must return, oldest first.
   class utf8_scoreboard;
      utf8d_pkg::utf8d_entry_type expected_q[$];
      int                         failures;
      logic [1:0]                 open_left;
      logic [1:0]                 open_len;
      logic [20:0]                gathered;

      function new();
         failures  = 0;
         open_left = utf8d_pkg::CNT_NONE;
         open_len  = utf8d_pkg::CNT_NONE;
         gathered  = '0;
      endfunction

      function void close_open();
         open_left = utf8d_pkg::CNT_NONE;
         open_len  = utf8d_pkg::CNT_NONE;
         gathered  = '0;
      endfunction

      // Returns 1 with the code point when the byte yields a result at once,
      // or 0 when it opens a multi-byte sequence.
      function bit take_lead(input logic [7:0] b, input logic [1:0] follow,
                             output logic [20:0] cp);
         logic [1:0] need;
         cp = '0;
         if (b[7] == 1'b0) begin
            cp = {14'd0, b[6:0]};
            return 1'b1;
         end
         if (b >= utf8d_pkg::LEAD_FOUR_LO && b <= utf8d_pkg::LEAD_FOUR_HI)
            need = utf8d_pkg::CNT_THREE;
         else if (b >= utf8d_pkg::LEAD_THREE_LO && b < utf8d_pkg::LEAD_FOUR_LO)
            need = utf8d_pkg::CNT_TWO;
         else if (b >= utf8d_pkg::LEAD_TWO_LO && b < utf8d_pkg::LEAD_THREE_LO)
            need = utf8d_pkg::CNT_ONE;
         else
            need = utf8d_pkg::CNT_NONE;
         if (need == utf8d_pkg::CNT_NONE || need > follow) begin
            cp = utf8d_pkg::REPLACEMENT;
            return 1'b1;
         end
         open_left = need;
         open_len  = need;
         case (need)
            utf8d_pkg::CNT_ONE: gathered = {16'd0, b[4:0]};
            utf8d_pkg::CNT_TWO: gathered = {17'd0, b[3:0]};
            default:            gathered = {18'd0, b[2:0]};
         endcase
         return 1'b0;
      endfunction

      function logic [20:0] scalar_or_replacement(input logic [20:0] code,
                                                  input logic [1:0]  len);
         logic [20:0] lowest;
         case (len)
            utf8d_pkg::CNT_ONE: lowest = utf8d_pkg::MIN_TWO;
            utf8d_pkg::CNT_TWO: lowest = utf8d_pkg::MIN_THREE;
            default:            lowest = utf8d_pkg::MIN_FOUR;
         endcase
         if (code < lowest || code > utf8d_pkg::MAX_SCALAR) return utf8d_pkg::REPLACEMENT;
         if (code >= utf8d_pkg::SURR_LOW && code <= utf8d_pkg::SURR_HIGH)
            return utf8d_pkg::REPLACEMENT;
         return code;
      endfunction

      function void note_byte(input logic [7:0] b, input logic [1:0] follow);
         logic [20:0]                codes[$];
         logic [20:0]                lead_cp;
         utf8d_pkg::utf8d_entry_type entry;
         if (open_left != utf8d_pkg::CNT_NONE) begin
            if (b[7:6] == 2'b10) begin
               gathered  = {gathered[14:0], b[5:0]};
               open_left = open_left - 2'd1;
               if (open_left == utf8d_pkg::CNT_NONE) begin
                  codes.push_back(scalar_or_replacement(gathered, open_len));
                  close_open();
               end else if (follow == 2'd0) begin
                  codes.push_back(utf8d_pkg::REPLACEMENT);
                  close_open();
               end
            end else begin
               // The breaking byte is decoded again as a new lead.
               codes.push_back(utf8d_pkg::REPLACEMENT);
               close_open();
               if (take_lead(b, follow, lead_cp)) codes.push_back(lead_cp);
            end
         end else if (take_lead(b, follow, lead_cp)) begin
            codes.push_back(lead_cp);
         end
         foreach (codes[k]) begin
            entry.code_point  = codes[k];
            entry.last_of_run = (k == codes.size() - 1);
            entry.end_of_text = (k == codes.size() - 1) && (follow == 2'd0);
            expected_q.push_back(entry);
         end
      endfunction

      function void check_code(input utf8d_pkg::utf8d_entry_type got);
         utf8d_pkg::utf8d_entry_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected response: code_point %h", got.code_point);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.code_point !== want.code_point) begin
            $error("code_point: expected %h, actual %h", want.code_point, got.code_point);
            failures++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run,
                   got.last_of_run);
            failures++;
         end
         if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %b, actual %b", want.end_of_text,
                   got.end_of_text);
            failures++;
         end
      endfunction

      function int waiting();
         return expected_q.size();
      endfunction

      function void flush_leftovers();
         foreach (expected_q[k]) begin
            $error("missing response: code_point %h", expected_q[k].code_point);
            failures++;
         end
         expected_q.delete();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   int   bytes_sent;
   bit   sender_calm;

   utf8d_req_if req_bus ();
   utf8d_rsp_if rsp_bus ();

   utf8_scoreboard decoder_sb;

   utf8_validating_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      utf8d_pkg::utf8d_entry_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.code_point  = rsp_bus.code_point;
         got.last_of_run = rsp_bus.last_of_run;
         got.end_of_text = rsp_bus.end_of_text;
         decoder_sb.check_code(got);
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // The receiver stalls for random stretches, with an occasional long run
   // of back-to-back acceptance.
   initial begin
      int stall;
      int open_run;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_len();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         open_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 8);
         repeat (open_run) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic [1:0] follow);
      int gap;
      gap = sender_calm ? 0 : idle_len();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.data_byte       <= b;
      req_bus.bytes_following <= follow;
      do @(posedge clock); while (!req_bus.ready);
      decoder_sb.note_byte(b, follow);
      bytes_sent++;
   endtask

   task automatic send_directed();
      send_byte(8'h00, 2'd3);
      send_byte(8'h7F, 2'd3);
      send_byte(8'hC2, 2'd3);   // smallest two-byte value
      send_byte(8'h80, 2'd3);
      send_byte(8'hDF, 2'd1);
      send_byte(8'hBF, 2'd0);
      send_byte(8'h80, 2'd3);   // continuation byte used as a lead
      send_byte(8'hC1, 2'd3);
      send_byte(8'hFF, 2'd3);
      send_byte(8'hE0, 2'd3);   // overlong three-byte form
      send_byte(8'h80, 2'd3);
      send_byte(8'h80, 2'd3);
      send_byte(8'hED, 2'd3);   // surrogate
      send_byte(8'hA0, 2'd3);
      send_byte(8'h80, 2'd3);
      send_byte(8'hF4, 2'd3);   // largest scalar value
      send_byte(8'h8F, 2'd3);
      send_byte(8'hBF, 2'd3);
      send_byte(8'hBF, 2'd3);
      send_byte(8'hF4, 2'd3);   // just above the code space
      send_byte(8'h90, 2'd3);
      send_byte(8'h80, 2'd3);
      send_byte(8'h80, 2'd3);
      send_byte(8'hE2, 2'd1);   // lead with too few bytes after it
      send_byte(8'hC3, 2'd3);   // broken by ASCII: two responses
      send_byte(8'h41, 2'd3);
      send_byte(8'hF0, 2'd3);   // text ends inside the sequence
      send_byte(8'h9F, 2'd0);
   endtask

   // Builds a short text, mostly well-formed encodings with a few overlong or
   // out-of-range values, sprinkles dropped and stray bytes, then sends it.
   task automatic send_text();
      logic [7:0]  text[$];
      logic [7:0]  piece[$];
      logic [20:0] v;
      int          n_chars;
      int          width;
      int          r;
      int          left;
      bit          lying;
      logic [1:0]  follow;
      n_chars = $urandom_range(1, 10);
      lying   = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (n_chars) begin
            r = $urandom_range(0, 9);
            width = (r < 4) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : 4;
            if ($urandom_range(0, 9) == 0) begin
               v = 21'($urandom_range(0, (width == 1) ? 127 : (1 << (5 * width + 1)) - 1));
            end else begin
               case (width)
                  1: v = 21'($urandom_range(0, 'h7F));
                  2: v = 21'($urandom_range('h80, 'h7FF));
                  3: v = 21'($urandom_range('h800, 'hFFFF));
                  default: v = 21'($urandom_range('h10000, 'h10FFFF));
               endcase
            end
            piece.delete();
            case (width)
               1: piece.push_back({1'b0, v[6:0]});
               2: begin
                  piece.push_back({3'b110, v[10:6]});
                  piece.push_back({2'b10, v[5:0]});
               end
               3: begin
                  piece.push_back({4'b1110, v[15:12]});
                  piece.push_back({2'b10, v[11:6]});
                  piece.push_back({2'b10, v[5:0]});
               end
               default: begin
                  piece.push_back({5'b11110, v[20:18]});
                  piece.push_back({2'b10, v[17:12]});
                  piece.push_back({2'b10, v[11:6]});
                  piece.push_back({2'b10, v[5:0]});
               end
            endcase
            foreach (piece[k]) begin
               r = $urandom_range(0, 99);
               if (r < 3) continue;
               if (r < 6) text.push_back(8'($urandom_range(0, 255)));
               else text.push_back(piece[k]);
            end
         end
      end
      foreach (text[k]) begin
         left   = text.size() - 1 - k;
         follow = (left > 3) ? 2'd3 : 2'(left);
         if (lying && $urandom_range(0, 2) == 0) follow = 2'($urandom_range(0, 3));
         send_byte(text[k], follow);
      end
   endtask

   initial begin
      bit paused;
      decoder_sb              = new();
      bytes_sent              = 0;
      sender_calm             = 1'b0;
      paused                  = 1'b0;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.data_byte       <= 8'h00;
      req_bus.bytes_following <= 2'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      while (bytes_sent < BYTE_TARGET) begin
         if (!paused && bytes_sent >= BYTE_TARGET / 2) begin
            // Hold off until the decoder has returned everything it owes.
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (decoder_sb.waiting() != 0);
            paused = 1'b1;
         end
         if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
         send_text();
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (decoder_sb.waiting() != 0);
      repeat (8) @(posedge clock);
      decoder_sb.flush_leftovers();
      if (decoder_sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_if.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8d_rsp_queue.sv
rtl/core/utf8_validating_decoder.sv
rtl/core/utf8d_checker.sv
verif/testbench.sv
